// ===== hw/rtl/rssfb_pkg.sv =====
`default_nettype none

package rssfb_pkg;

  localparam int RUN_LEN   = 10;
  localparam int IDX_W     = $clog2(RUN_LEN);
  localparam int NUM_W     = 16;
  localparam int MAG_W     = 10;
  localparam int SEG_W     = 7;
  localparam int POS_N     = 3;
  localparam int ROW_N     = 3;
  localparam int IN_DATA_W = 56;
  localparam int OUT_DATA_W = 16;

  localparam logic [MAG_W-1:0] NUM_MAX  = MAG_W'(999);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RUN_LEN - 1);
  localparam logic [7:0]       CHAR_NL  = 8'h0A;

  // segment bit positions in an 8-bit pattern
  localparam int SEG_DP = 7;
  localparam int SEG_A  = 6;
  localparam int SEG_B  = 5;
  localparam int SEG_C  = 4;
  localparam int SEG_D  = 3;
  localparam int SEG_E  = 2;
  localparam int SEG_F  = 1;
  localparam int SEG_G  = 0;

  // colour bit positions
  localparam int COL_R = 2;
  localparam int COL_G = 1;
  localparam int COL_B = 0;

  // shift register within one digit, in send order
  localparam logic [1:0] ROW_FAR  = 2'd0;
  localparam logic [1:0] ROW_MID  = 2'd1;
  localparam logic [1:0] ROW_NEAR = 2'd2;

  typedef enum logic {
    CMD_NUMBER = 1'b0,
    CMD_TEXT   = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t              command;
    logic [1:0]        target_display;
    logic signed [15:0] number;
    logic [7:0]        char_first;
    logic [7:0]        char_second;
    logic [7:0]        char_third;
    logic [2:0]        colour;
    logic [7:0]        indicator_leds;
  } raw_t;

  typedef struct packed {
    cmd_t                         command;
    logic [1:0]                   sel;
    logic [2:0]                   colour;
    logic [7:0]                   leds;
    logic [MAG_W-1:0]             mag;
    logic [3:0]                   hund;
    logic [6:0]                   rem;
    logic [3:0]                   tens;
    logic [POS_N-1:0][SEG_W-1:0]  seg;
    logic [POS_N-1:0]             lit;
  } item_t;

  typedef struct packed {
    logic [1:0]               sel;
    logic [RUN_LEN-1:0][7:0]  bytes;
  } frame_t;

  function automatic logic [SEG_W-1:0] digit_seg(input logic [3:0] d);
    logic [SEG_W-1:0] s;
    case (d)
      4'd0:    s = 7'h7E;
      4'd1:    s = 7'h30;
      4'd2:    s = 7'h6D;
      4'd3:    s = 7'h79;
      4'd4:    s = 7'h33;
      4'd5:    s = 7'h5B;
      4'd6:    s = 7'h5F;
      4'd7:    s = 7'h70;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h7B;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

  function automatic logic [SEG_W-1:0] char_seg(input logic [7:0] c);
    logic [SEG_W-1:0] s;
    case (c)
      8'h41: s = 7'h77;  // A
      8'h42: s = 7'h7F;
      8'h43: s = 7'h4E;
      8'h44: s = 7'h7E;
      8'h45: s = 7'h4F;
      8'h46: s = 7'h47;
      8'h47: s = 7'h5F;
      8'h48: s = 7'h37;
      8'h49: s = 7'h06;
      8'h4A: s = 7'h3C;
      8'h4B: s = 7'h37;
      8'h4C: s = 7'h0E;
      8'h4E: s = 7'h15;  // N
      8'h4F: s = 7'h7E;
      8'h50: s = 7'h67;
      8'h51: s = 7'h73;
      8'h52: s = 7'h05;
      8'h53: s = 7'h5B;
      8'h54: s = 7'h0F;
      8'h55: s = 7'h3E;
      8'h56: s = 7'h3E;
      8'h58: s = 7'h37;  // X
      8'h59: s = 7'h3B;
      8'h5A: s = 7'h6D;
      8'h61: s = 7'h77;  // a
      8'h62: s = 7'h1F;
      8'h63: s = 7'h0D;
      8'h64: s = 7'h3D;
      8'h65: s = 7'h4F;
      8'h66: s = 7'h47;
      8'h67: s = 7'h7B;
      8'h68: s = 7'h17;
      8'h69: s = 7'h04;
      8'h6A: s = 7'h38;
      8'h6B: s = 7'h37;
      8'h6C: s = 7'h06;
      8'h6E: s = 7'h15;  // n
      8'h6F: s = 7'h1D;
      8'h70: s = 7'h67;
      8'h71: s = 7'h73;
      8'h72: s = 7'h05;
      8'h73: s = 7'h5B;
      8'h74: s = 7'h0F;
      8'h75: s = 7'h1C;
      8'h76: s = 7'h1C;
      8'h78: s = 7'h37;  // x
      8'h79: s = 7'h3B;
      8'h7A: s = 7'h6D;
      8'h5F: s = 7'h08;  // underscore
      8'h2D: s = 7'h08;  // dash
      default: begin
        if (c >= 8'h30 && c <= 8'h39) begin
          s = digit_seg(c[3:0]);
        end else begin
          s = 7'h00;
        end
      end
    endcase
    return s;
  endfunction

  // One wired byte of a digit: every bit is one segment AND one colour.
  function automatic logic [7:0] encode_byte(input logic [1:0] row,
                                             input logic [7:0] s,
                                             input logic [2:0] c);
    logic [7:0] v;
    case (row)
      ROW_FAR: v = {s[SEG_B] & c[COL_R], s[SEG_B] & c[COL_B],
                    s[SEG_A] & c[COL_R], s[SEG_A] & c[COL_G],
                    s[SEG_A] & c[COL_B], s[SEG_G] & c[COL_R],
                    s[SEG_G] & c[COL_B], s[SEG_F] & c[COL_B]};
      ROW_MID: v = {s[SEG_B] & c[COL_G], s[SEG_G] & c[COL_G],
                    s[SEG_F] & c[COL_R], s[SEG_F] & c[COL_G],
                    s[SEG_DP] & c[COL_B], s[SEG_C] & c[COL_G],
                    s[SEG_E] & c[COL_R], s[SEG_E] & c[COL_B]};
      ROW_NEAR: v = {s[SEG_DP] & c[COL_R], s[SEG_DP] & c[COL_G],
                     s[SEG_C] & c[COL_R], s[SEG_C] & c[COL_B],
                     s[SEG_D] & c[COL_R], s[SEG_D] & c[COL_G],
                     s[SEG_D] & c[COL_B], s[SEG_E] & c[COL_G]};
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/rssfb_digits.sv =====
`default_nettype none

module rssfb_digits (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire rssfb_pkg::raw_t  in_item,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output rssfb_pkg::item_t      out_item
);

  logic v1, v2, v3, v4, v5;
  rssfb_pkg::item_t d1, d2, d3, d4, d5;
  rssfb_pkg::item_t n1, n2, n3, n4, n5;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  logic [15:0] absval;
  logic        nl0, nl1, nl2;
  logic [15:0] prod41;
  logic [9:0]  hund100;
  logic [9:0]  rem_full;
  logic [13:0] prod103;
  logic [6:0]  tens10;
  logic [6:0]  ones_full;
  logic [3:0]  ones;

  assign rdy5 = !v5 || out_ready;
  assign rdy4 = !v4 || rdy5;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign in_ready = rdy1;

  // stage 1: magnitude with saturation, text segments with newline blanking
  always_comb begin
    absval = in_item.number[15] ? (~in_item.number + 16'd1) : in_item.number;
    nl0 = in_item.char_first  == rssfb_pkg::CHAR_NL;
    nl1 = nl0 || in_item.char_second == rssfb_pkg::CHAR_NL;
    nl2 = nl1 || in_item.char_third  == rssfb_pkg::CHAR_NL;
    n1 = '0;
    n1.command = in_item.command;
    n1.sel     = in_item.target_display;
    n1.colour  = in_item.colour;
    n1.leds    = in_item.indicator_leds;
    n1.mag     = (absval > 16'(rssfb_pkg::NUM_MAX)) ? rssfb_pkg::NUM_MAX
                                                    : absval[9:0];
    n1.seg[0]  = nl0 ? '0 : rssfb_pkg::char_seg(in_item.char_first);
    n1.seg[1]  = nl1 ? '0 : rssfb_pkg::char_seg(in_item.char_second);
    n1.seg[2]  = nl2 ? '0 : rssfb_pkg::char_seg(in_item.char_third);
  end

  // stage 2: hundreds = mag * 41 >> 12, exact below 1000
  always_comb begin
    prod41 = 16'(d1.mag) * 16'd41;
    n2 = d1;
    n2.hund = prod41[15:12];
  end

  // stage 3: remainder below 100
  always_comb begin
    hund100  = {d2.hund, 6'b0} + {1'b0, d2.hund, 5'b0} + {4'b0, d2.hund, 2'b0};
    rem_full = d2.mag - hund100;
    n3 = d2;
    n3.rem = rem_full[6:0];
  end

  // stage 4: tens = rem * 103 >> 10, exact below 100
  always_comb begin
    prod103 = 14'(d3.rem) * 14'd103;
    n4 = d3;
    n4.tens = prod103[13:10];
  end

  // stage 5: ones digit; in number mode digit segments and leading-zero blanking
  always_comb begin
    tens10    = {d4.tens, 3'b0} + {2'b0, d4.tens, 1'b0};
    ones_full = d4.rem - tens10;
    ones      = ones_full[3:0];
    n5 = d4;
    if (d4.command == rssfb_pkg::CMD_NUMBER) begin
      n5.seg[0] = rssfb_pkg::digit_seg(d4.hund);
      n5.seg[1] = rssfb_pkg::digit_seg(d4.tens);
      n5.seg[2] = rssfb_pkg::digit_seg(ones);
      n5.lit[0] = d4.hund != 4'd0;
      n5.lit[1] = d4.hund != 4'd0 || d4.tens != 4'd0;
      n5.lit[2] = 1'b1;
    end else begin
      n5.lit = '1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) d1 <= n1;
    if (rdy2) d2 <= n2;
    if (rdy3) d3 <= n3;
    if (rdy4) d4 <= n4;
    if (rdy5) d5 <= n5;
  end

  assign out_valid = v5;
  assign out_item  = d5;

`ifndef SYNTHESIS
  a_mag_sat: assert property (@(posedge clk) disable iff (rst)
    v1 |-> d1.mag <= rssfb_pkg::NUM_MAX)
    else $error("magnitude above saturation limit");
  a_hund_range: assert property (@(posedge clk) disable iff (rst)
    v2 |-> (d2.hund <= 4'd9 && 10'(d2.hund) * 10'd100 <= d2.mag &&
            d2.mag - 10'(d2.hund) * 10'd100 < 10'd100))
    else $error("hundreds digit wrong");
  a_tens_range: assert property (@(posedge clk) disable iff (rst)
    v4 |-> (d4.tens <= 4'd9 && 7'(d4.tens) * 7'd10 <= d4.rem &&
            d4.rem - 7'(d4.tens) * 7'd10 < 7'd10))
    else $error("tens digit wrong");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/rssfb_encode.sv =====
`default_nettype none

module rssfb_encode (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire rssfb_pkg::item_t  in_item,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output rssfb_pkg::frame_t      out_frame
);

  logic              v;
  rssfb_pkg::frame_t fr;
  rssfb_pkg::frame_t fr_next;
  logic [2:0]        col_p;

  assign in_ready = !v || out_ready;

  // LED byte first, then far/mid/near byte of each digit position
  always_comb begin
    fr_next = '0;
    col_p   = '0;
    fr_next.sel      = in_item.sel;
    fr_next.bytes[0] = in_item.leds;
    for (int p = 0; p < rssfb_pkg::POS_N; p++) begin
      col_p = in_item.lit[p] ? in_item.colour : 3'b000;
      for (int r = 0; r < rssfb_pkg::ROW_N; r++) begin
        fr_next.bytes[1 + p * rssfb_pkg::ROW_N + r] =
          rssfb_pkg::encode_byte(2'(r), {1'b0, in_item.seg[p]}, col_p);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (in_ready) begin
      v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) fr <= fr_next;
  end

  assign out_valid = v;
  assign out_frame = fr;

endmodule

`default_nettype wire

// ===== hw/rtl/rssfb_serial.sv =====
`default_nettype none

module rssfb_serial (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire rssfb_pkg::frame_t  in_frame,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [7:0]              out_byte,
  output logic [1:0]              out_sel,
  output logic                    out_last
);

  logic                        fv;
  rssfb_pkg::frame_t           fr;
  logic [rssfb_pkg::IDX_W-1:0] idx;
  logic                        ov;
  logic [7:0]                  obyte;
  logic [1:0]                  osel;
  logic                        olast;
  logic                        load_out;
  logic                        at_last;

  assign at_last  = idx == rssfb_pkg::LAST_IDX;
  assign load_out = fv && (!ov || out_ready);
  // take the next frame as the last byte of the current one moves out
  assign in_ready = !fv || (load_out && at_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      fv  <= 1'b0;
      ov  <= 1'b0;
      idx <= '0;
    end else begin
      if (in_valid && in_ready) begin
        fv <= 1'b1;
      end else if (load_out && at_last) begin
        fv <= 1'b0;
      end
      if (load_out) begin
        ov  <= 1'b1;
        idx <= at_last ? '0 : idx + 1'b1;
      end else if (out_ready) begin
        ov <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) fr <= in_frame;
    if (load_out) begin
      obyte <= fr.bytes[idx];
      osel  <= fr.sel;
      olast <= at_last;
    end
  end

  assign out_valid = ov;
  assign out_byte  = obyte;
  assign out_sel   = osel;
  assign out_last  = olast;

`ifndef SYNTHESIS
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    idx <= rssfb_pkg::LAST_IDX)
    else $error("byte index out of range");
  a_idx_held: assert property (@(posedge clk) disable iff (rst)
    idx != '0 |-> fv)
    else $error("run in progress without a frame");
  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    load_out |=> (out_valid && out_last == $past(at_last)))
    else $error("last flag does not follow byte index");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && fv) |-> (load_out && at_last))
    else $error("frame replaced before its run finished");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/rgb_seven_segment_frame_builder_top.sv =====
// Path: each command passes the digit and encode stages into the serializer,
//   which takes a new frame only as the last byte of the current one leaves.
// Throughput: the serializer sends one byte per cycle through a single output
//   register while m_tready is high; the 6-stage front end is free.
// Reset (rst, synchronous) clears all valid bits and the byte counter; data
//   registers keep their contents.
`default_nettype none

module rgb_seven_segment_frame_builder_top (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  // target_display[1:0], number[17:2], char_first[25:18], char_second[33:26],
  // char_third[41:34], colour[44:42], indicator_leds[52:45], zero pad
  input  wire logic [rssfb_pkg::IN_DATA_W-1:0]     s_tdata,
  // command[0]
  input  wire logic                                s_tuser,
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  // shift_byte[7:0], display_sel[9:8], zero pad
  output logic [rssfb_pkg::OUT_DATA_W-1:0]         m_tdata,
  output logic                                     m_tlast
);

  rssfb_pkg::raw_t   raw;
  rssfb_pkg::item_t  dig_item;
  rssfb_pkg::frame_t enc_frame;
  logic              dig_valid, dig_ready;
  logic              enc_valid, enc_ready;
  logic [7:0]        out_byte;
  logic [1:0]        out_sel;

  always_comb begin
    raw.command        = rssfb_pkg::cmd_t'(s_tuser);
    raw.target_display = s_tdata[1:0];
    raw.number         = s_tdata[17:2];
    raw.char_first     = s_tdata[25:18];
    raw.char_second    = s_tdata[33:26];
    raw.char_third     = s_tdata[41:34];
    raw.colour         = s_tdata[44:42];
    raw.indicator_leds = s_tdata[52:45];
  end

  rssfb_digits u_digits (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_item   (raw),
    .out_valid (dig_valid),
    .out_ready (dig_ready),
    .out_item  (dig_item)
  );

  rssfb_encode u_encode (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dig_valid),
    .in_ready  (dig_ready),
    .in_item   (dig_item),
    .out_valid (enc_valid),
    .out_ready (enc_ready),
    .out_frame (enc_frame)
  );

  rssfb_serial u_serial (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (enc_valid),
    .in_ready  (enc_ready),
    .in_frame  (enc_frame),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_byte  (out_byte),
    .out_sel   (out_sel),
    .out_last  (m_tlast)
  );

  assign m_tdata = {6'b0, out_sel, out_byte};

endmodule

`default_nettype wire

// ===== bench/rgb_seven_segment_frame_builder_top_test.sv =====
`timescale 1ns / 100ps

module rgb_seven_segment_frame_builder_top_test;
  import rssfb_pkg::*;

  typedef struct {
    logic [7:0] shift_byte;
    logic [1:0] sel;
    logic       last;
  } chain_byte_t;

  typedef struct {
    cmd_t               cmd;
    logic [1:0]         sel;
    logic signed [15:0] num;
    logic [7:0]         c1;
    logic [7:0]         c2;
    logic [7:0]         c3;
    logic [2:0]         col;
    logic [7:0]         leds;
    bit                 typed;
    logic [79:0]        gold;   // byte k at bits 8k+7:8k
  } cmd_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  s_tuser = CMD_NUMBER;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tlast;

  chain_byte_t pending_bytes[$];
  cmd_row_t    directed_rows[$];
  int          mismatches = 0;

  rgb_seven_segment_frame_builder_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin
    #2000000;
    $display("rgb_seven_segment_frame_builder_top_test NOT OK");
    $finish;
  end

  function automatic logic [7:0] numeral_pattern(input int d);
    case (d)
      0: return 8'h7E;
      1: return 8'h30;
      2: return 8'h6D;
      3: return 8'h79;
      4: return 8'h33;
      5: return 8'h5B;
      6: return 8'h5F;
      7: return 8'h70;
      8: return 8'h7F;
      default: return 8'h7B;
    endcase
  endfunction

  function automatic logic [7:0] glyph_pattern(input logic [7:0] c);
    case (c)
      "A", "a":                return 8'h77;
      "B":                     return 8'h7F;
      "C":                     return 8'h4E;
      "D", "O":                return 8'h7E;
      "E", "e":                return 8'h4F;
      "F", "f":                return 8'h47;
      "G":                     return 8'h5F;
      "H", "K", "X", "k", "x": return 8'h37;
      "I", "l":                return 8'h06;
      "J":                     return 8'h3C;
      "L":                     return 8'h0E;
      "N", "n":                return 8'h15;
      "P", "p":                return 8'h67;
      "Q", "q":                return 8'h73;
      "R", "r":                return 8'h05;
      "S", "s":                return 8'h5B;
      "T", "t":                return 8'h0F;
      "U", "V":                return 8'h3E;
      "Y", "y":                return 8'h3B;
      "Z", "z":                return 8'h6D;
      "b":                     return 8'h1F;
      "c":                     return 8'h0D;
      "d":                     return 8'h3D;
      "g":                     return 8'h7B;
      "h":                     return 8'h17;
      "i":                     return 8'h04;
      "j":                     return 8'h38;
      "o":                     return 8'h1D;
      "u", "v":                return 8'h1C;
      "_", "-":                return 8'h08;
      default: begin
        if (c >= "0" && c <= "9") return numeral_pattern(c - "0");
        return 8'h00;
      end
    endcase
  endfunction

  // Which segment and which colour flag feed output bit b of register row.
  function automatic logic [4:0] tap_of(input int row, input int b);
    case (row * 8 + b)
      0:  return {3'(SEG_F),  2'(COL_B)};
      1:  return {3'(SEG_G),  2'(COL_B)};
      2:  return {3'(SEG_G),  2'(COL_R)};
      3:  return {3'(SEG_A),  2'(COL_B)};
      4:  return {3'(SEG_A),  2'(COL_G)};
      5:  return {3'(SEG_A),  2'(COL_R)};
      6:  return {3'(SEG_B),  2'(COL_B)};
      7:  return {3'(SEG_B),  2'(COL_R)};
      8:  return {3'(SEG_E),  2'(COL_B)};
      9:  return {3'(SEG_E),  2'(COL_R)};
      10: return {3'(SEG_C),  2'(COL_G)};
      11: return {3'(SEG_DP), 2'(COL_B)};
      12: return {3'(SEG_F),  2'(COL_G)};
      13: return {3'(SEG_F),  2'(COL_R)};
      14: return {3'(SEG_G),  2'(COL_G)};
      15: return {3'(SEG_B),  2'(COL_G)};
      16: return {3'(SEG_E),  2'(COL_G)};
      17: return {3'(SEG_D),  2'(COL_B)};
      18: return {3'(SEG_D),  2'(COL_G)};
      19: return {3'(SEG_D),  2'(COL_R)};
      20: return {3'(SEG_C),  2'(COL_B)};
      21: return {3'(SEG_C),  2'(COL_R)};
      22: return {3'(SEG_DP), 2'(COL_G)};
      default: return {3'(SEG_DP), 2'(COL_R)};
    endcase
  endfunction

  function automatic logic [7:0] wire_byte(input int row, input logic [7:0] seg,
                                           input logic [2:0] col);
    logic [7:0] v;
    logic [4:0] t;
    v = '0;
    for (int b = 0; b < 8; b++) begin
      t = tap_of(row, b);
      v[b] = seg[t[4:2]] & col[t[1:0]];
    end
    return v;
  endfunction

  function automatic void push_byte(input logic [7:0] v, input logic [1:0] sel,
                                    input int k);
    chain_byte_t e;
    e.shift_byte = v;
    e.sel        = sel;
    e.last       = (k == RUN_LEN - 1);
    pending_bytes.push_back(e);
  endfunction

  function automatic void predict_frame(input cmd_row_t r);
    logic [7:0] glyph [3];
    logic [2:0] tint [3];
    logic [7:0] chars [3];
    int         mag;
    int         h;
    int         t;
    int         o;
    bit         ended;
    if (r.cmd == CMD_NUMBER) begin
      // absolute value first, then saturate
      mag = r.num;
      if (mag < 0) mag = -mag;
      if (mag > 999) mag = 999;
      h = mag / 100;
      t = (mag / 10) % 10;
      o = mag % 10;
      glyph[0] = numeral_pattern(h);
      glyph[1] = numeral_pattern(t);
      glyph[2] = numeral_pattern(o);
      tint[0] = (h == 0) ? 3'b000 : r.col;
      tint[1] = (h == 0 && t == 0) ? 3'b000 : r.col;
      tint[2] = r.col;
    end else begin
      chars[0] = r.c1;
      chars[1] = r.c2;
      chars[2] = r.c3;
      ended = 1'b0;
      for (int p = 0; p < 3; p++) begin
        if (chars[p] == CHAR_NL) ended = 1'b1;
        glyph[p] = ended ? 8'h00 : glyph_pattern(chars[p]);
        tint[p] = r.col;
      end
    end
    push_byte(r.leds, r.sel, 0);
    for (int p = 0; p < 3; p++)
      for (int w = 0; w < 3; w++)
        push_byte(wire_byte(w, glyph[p], tint[p]), r.sel, 1 + p * 3 + w);
  endfunction

  function automatic void add_row(input cmd_t cmd, input logic [1:0] sel,
                                  input logic signed [15:0] num,
                                  input logic [7:0] c1, input logic [7:0] c2,
                                  input logic [7:0] c3, input logic [2:0] col,
                                  input logic [7:0] leds, input bit typed,
                                  input logic [79:0] gold);
    cmd_row_t r;
    r.cmd = cmd; r.sel = sel; r.num = num;
    r.c1 = c1; r.c2 = c2; r.c3 = c3;
    r.col = col; r.leds = leds;
    r.typed = typed; r.gold = gold;
    directed_rows.push_back(r);
  endfunction

  // Quiet stretches: for a run of items either no waits at all or random waits.
  function automatic int draw_wait(inout int left, inout bit quiet);
    if (left == 0) begin
      quiet = ($urandom_range(0, 2) == 0);
      left  = $urandom_range(10, 40);
    end
    left--;
    return quiet ? 0 : $urandom_range(0, 15);
  endfunction

  function automatic logic [7:0] random_char();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return CHAR_NL;
    if (pick <= 2) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(8'h20, 8'h7E));
  endfunction

  function automatic logic signed [15:0] random_number();
    int pick;
    int v;
    pick = $urandom_range(0, 9);
    if (pick < 3) return 16'($urandom_range(0, 65535));
    if (pick < 5) v = $urandom_range(0, 120);
    else          v = $urandom_range(0, 1100);
    return $urandom_range(0, 1) ? 16'(-v) : 16'(v);
  endfunction

  task automatic send_command(input cmd_row_t r, inout int left, inout bit quiet);
    int gap;
    gap = draw_wait(left, quiet);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= r.cmd;
    s_tdata  <= {3'b000, r.leds, r.col, r.c3, r.c2, r.c1, r.num, r.sel};
    do @(posedge clk); while (s_tready !== 1'b1);
    if (r.typed) begin
      for (int k = 0; k < RUN_LEN; k++) push_byte(r.gold[k*8 +: 8], r.sel, k);
    end else begin
      predict_frame(r);
    end
  endtask

  // Output side: draw a stall per item, then take one byte and check it.
  initial begin
    int          stall;
    int          rx_left;
    bit          rx_quiet;
    chain_byte_t want;
    rx_left  = 0;
    rx_quiet = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      stall = draw_wait(rx_left, rx_quiet);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (m_tvalid !== 1'b1);
      if (pending_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected byte %h sel %0d last %b", m_tdata[7:0],
                   m_tdata[9:8], m_tlast);
      end else begin
        want = pending_bytes.pop_front();
        if (m_tdata[7:0] !== want.shift_byte || m_tdata[9:8] !== want.sel ||
            m_tlast !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("byte mismatch: expected %h sel %0d last %b, got %h sel %0d last %b",
                     want.shift_byte, want.sel, want.last,
                     m_tdata[7:0], m_tdata[9:8], m_tlast);
        end
      end
    end
  end

  initial begin
    cmd_row_t r;
    int       tx_left;
    bit       tx_quiet;
    tx_left  = 0;
    tx_quiet = 1'b0;

    // number mode
    add_row(CMD_NUMBER, 2'd1, 16'sd0,     0, 0, 0, 3'd0, 8'hFF, 1,
            80'h000000000000000000FF);
    add_row(CMD_NUMBER, 2'd2, 16'sd0,     0, 0, 0, 3'd7, 8'h00, 0, '0);
    add_row(CMD_NUMBER, 2'd3, 16'sd999,   0, 0, 0, 3'd7, 8'hA5, 0, '0);
    add_row(CMD_NUMBER, 2'd1, 16'sd1000,  0, 0, 0, 3'd5, 8'h5A, 0, '0);
    add_row(CMD_NUMBER, 2'd2, 16'sd32767, 0, 0, 0, 3'd7, 8'h01, 0, '0);
    add_row(CMD_NUMBER, 2'd3, -16'sd32768, 0, 0, 0, 3'd6, 8'h80, 0, '0);
    add_row(CMD_NUMBER, 2'd1, -16'sd1,    0, 0, 0, 3'd1, 8'h11, 0, '0);
    add_row(CMD_NUMBER, 2'd2, -16'sd999,  0, 0, 0, 3'd2, 8'h22, 0, '0);
    add_row(CMD_NUMBER, 2'd3, 16'sd5,     0, 0, 0, 3'd3, 8'h33, 0, '0);
    add_row(CMD_NUMBER, 2'd1, 16'sd50,    0, 0, 0, 3'd4, 8'h44, 0, '0);
    add_row(CMD_NUMBER, 2'd2, 16'sd105,   0, 0, 0, 3'd7, 8'h55, 0, '0);
    add_row(CMD_NUMBER, 2'd0, 16'sd7,     0, 0, 0, 3'd7, 8'h66, 0, '0);
    // text mode
    add_row(CMD_TEXT, 2'd1, 16'sd0, CHAR_NL, "A", "B", 3'd7, 8'h3C, 1,
            80'h0000000000000000003C);
    add_row(CMD_TEXT, 2'd2, 16'sd0, "A", CHAR_NL, "Z", 3'd7, 8'h00, 0, '0);
    add_row(CMD_TEXT, 2'd3, 16'sd0, "8", "8", CHAR_NL, 3'd7, 8'hFF, 0, '0);
    add_row(CMD_TEXT, 2'd1, 16'sd0, "M", "W", "m", 3'd7, 8'h81, 1,
            80'h00000000000000000081);
    add_row(CMD_TEXT, 2'd2, 16'sd0, 8'hFF, 8'h80, 8'h00, 3'd7, 8'h7E, 1,
            80'h0000000000000000007E);
    add_row(CMD_TEXT, 2'd3, 16'sd0, "-", "_", "0", 3'd7, 8'h18, 0, '0);
    add_row(CMD_TEXT, 2'd0, 16'sd0, "H", "i", "9", 3'd0, 8'hC3, 1,
            80'h000000000000000000C3);
    add_row(CMD_TEXT, 2'd1, 16'sd0, "a", "z", "q", 3'd5, 8'h99, 0, '0);
    add_row(CMD_TEXT, 2'd2, 16'sd0, "x", "y", "Z", 3'd2, 8'hE7, 0, '0);
    add_row(CMD_TEXT, 2'd3, 16'sd0, "w", "8", "8", 3'd1, 8'h42, 0, '0);

    while (rst) @(posedge clk);

    foreach (directed_rows[i]) send_command(directed_rows[i], tx_left, tx_quiet);

    for (int n = 0; n < 390; n++) begin
      r.cmd   = $urandom_range(0, 9) < 5 ? CMD_NUMBER : CMD_TEXT;
      r.sel   = 2'($urandom_range(0, 3));
      r.num   = random_number();
      r.c1    = random_char();
      r.c2    = random_char();
      r.c3    = random_char();
      r.col   = 3'($urandom_range(0, 7));
      r.leds  = 8'($urandom_range(0, 255));
      r.typed = 1'b0;
      r.gold  = '0;
      send_command(r, tx_left, tx_quiet);
    end
    s_tvalid <= 1'b0;

    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("rgb_seven_segment_frame_builder_top_test OK");
    end else begin
      $display("rgb_seven_segment_frame_builder_top_test NOT OK");
    end
    $finish;
  end

endmodule
